>>> hdl/rcrs_pkg.sv
// Shared types and codes for the rotated clip rectangle stack.
// Holds command, status, rotation and config index codes, the rectangle
// structs and the configuration bundle. No dependencies.
package rcrs_pkg;

    // Width of the internal geometry arithmetic (covers every mapped sum)
    localparam int GW = 20;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef enum logic [2:0] {
        CFG_WINDOW_WIDTH  = 3'd0,
        CFG_WINDOW_HEIGHT = 3'd1,
        CFG_SCREEN_WIDTH  = 3'd2,
        CFG_SCREEN_HEIGHT = 3'd3,
        CFG_OFFSET_X      = 3'd4,
        CFG_OFFSET_Y      = 3'd5,
        CFG_ROTATION      = 3'd6
    } t_cfg_idx;

    // Rectangle as given by the host
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } t_raw_rect;

    // Mapped and clipped rectangle in window pixels
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] w;
        logic        [14:0] h;
    } t_clip_rect;

    typedef struct packed {
        logic [11:0] window_width;
        logic [11:0] window_height;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [11:0] offset_x;
        logic [11:0] offset_y;
        t_rot        rotation;
    } t_cfg;

endpackage

>>> hdl/rcrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for both stack stores. No dependencies.
module rcrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rcrs_geom.sv
// Rectangle geometry: zero-size fill, rotation mapping, clipping against the
// stack top with saturation, and the visibility test. Depends on rcrs_pkg.
module rcrs_geom (
    input  rcrs_pkg::t_cfg       i_cfg,
    input  rcrs_pkg::t_raw_rect  i_raw,
    input  rcrs_pkg::t_clip_rect i_clip_top,
    input  rcrs_pkg::t_raw_rect  i_raw_top,
    input  logic                 i_top_vld,
    output rcrs_pkg::t_clip_rect o_push_rect,
    output logic                 o_visible
);

    localparam int GW = rcrs_pkg::GW;

    logic signed [GW-1:0] ww, wh, sw, sh, ox, oy;
    logic signed [GW-1:0] rx, ry, rw, rh;
    logic signed [GW-1:0] bw, bh;
    logic signed [GW-1:0] mx, my, mw, mh;
    logic signed [GW-1:0] tx, ty, tw, th, t_right, t_bot;
    logic signed [GW-1:0] cx, cy, cw, ch;
    logic signed [GW-1:0] ax, ay, aw, ah;
    logic                 c_neg_x, c_neg_y, c_edge, scr_xo, scr_yo, top_xo, top_yo;

    // Saturate to a signed 16-bit coordinate
    function automatic logic signed [15:0] sat_pos(input logic signed [GW-1:0] v);
        logic signed [15:0] res;
        if (v < -32768) begin
            res = -16'sd32768;
        end else if (v > 32767) begin
            res = 16'sd32767;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Saturate to an unsigned 15-bit size
    function automatic logic [14:0] sat_size(input logic signed [GW-1:0] v);
        logic [14:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > 32767) begin
            res = 15'h7FFF;
        end else begin
            res = v[14:0];
        end
        return res;
    endfunction

    // Extend configuration and input fields to the working width
    assign ww = {{(GW-12){1'b0}}, i_cfg.window_width};
    assign wh = {{(GW-12){1'b0}}, i_cfg.window_height};
    assign sw = {{(GW-12){1'b0}}, i_cfg.screen_width};
    assign sh = {{(GW-12){1'b0}}, i_cfg.screen_height};
    assign ox = {{(GW-12){1'b0}}, i_cfg.offset_x};
    assign oy = {{(GW-12){1'b0}}, i_cfg.offset_y};
    assign rx = {{(GW-16){i_raw.x[15]}}, i_raw.x};
    assign ry = {{(GW-16){i_raw.y[15]}}, i_raw.y};
    assign rw = {{(GW-16){i_raw.w[15]}}, i_raw.w};
    assign rh = {{(GW-16){i_raw.h[15]}}, i_raw.h};

    // Fill a zero size up to the logical screen edge
    assign bw = (rw == 0) ? (sw - rx) : rw;
    assign bh = (rh == 0) ? (sh - ry) : rh;

    // Map through the configured quarter-turn rotation
    always_comb begin
        case (i_cfg.rotation)
            rcrs_pkg::ROT_0: begin
                mx = ox + rx;
                my = oy + ry;
                mw = bw;
                mh = bh;
            end
            rcrs_pkg::ROT_90: begin
                mx = ww - oy - ry - bh;
                my = ox + rx;
                mw = bh;
                mh = bw;
            end
            rcrs_pkg::ROT_180: begin
                mx = ww - ox - rx - bw;
                my = wh - oy - ry - bh;
                mw = bw;
                mh = bh;
            end
            default: begin
                mx = oy + ry;
                my = wh - ox - rx - bw;
                mw = bh;
                mh = bw;
            end
        endcase
    end

    // Intersect with the current top; the new left edge feeds the width test
    assign tx      = {{(GW-16){i_clip_top.x[15]}}, i_clip_top.x};
    assign ty      = {{(GW-16){i_clip_top.y[15]}}, i_clip_top.y};
    assign tw      = {{(GW-15){1'b0}}, i_clip_top.w};
    assign th      = {{(GW-15){1'b0}}, i_clip_top.h};
    assign t_right = tx + tw;
    assign t_bot   = ty + th;

    always_comb begin
        cx = mx;
        cy = my;
        cw = mw;
        ch = mh;
        if (i_top_vld) begin
            if (tx > mx) cx = tx;
            if (ty > my) cy = ty;
            if (t_right < cx + mw) cw = t_right - cx;
            if (t_bot < cy + mh) ch = t_bot - cy;
        end
    end

    assign o_push_rect.x = sat_pos(cx);
    assign o_push_rect.y = sat_pos(cy);
    assign o_push_rect.w = sat_size(cw);
    assign o_push_rect.h = sat_size(ch);

    // Visibility against the window
    assign c_neg_x = (rw > 0) && (rx + rw <= 0);
    assign c_neg_y = (rh > 0) && (ry + rh <= 0);
    assign c_edge  = (rx == ww) || (ry == wh);
    assign scr_xo  = (rx >= 0 && rx <= ww) || (rx <= 0 && rx + rw >= 0);
    assign scr_yo  = (ry >= 0 && ry <= wh) || (ry <= 0 && ry + rh >= 0);

    // Visibility against the raw top rectangle
    assign ax     = {{(GW-16){i_raw_top.x[15]}}, i_raw_top.x};
    assign ay     = {{(GW-16){i_raw_top.y[15]}}, i_raw_top.y};
    assign aw     = {{(GW-16){i_raw_top.w[15]}}, i_raw_top.w};
    assign ah     = {{(GW-16){i_raw_top.h[15]}}, i_raw_top.h};
    assign top_xo = (ax >= rx && ax <= rx + rw) || (rx >= ax && rx <= ax + aw);
    assign top_yo = (ay >= ry && ay <= ry + rh) || (ry >= ay && ry <= ay + ah);

    assign o_visible = !c_neg_x && !c_neg_y && !c_edge && scr_xo && scr_yo &&
                       (!i_top_vld || (top_xo && top_yo));

endmodule

>>> hdl/rotated_clip_rect_stack_top.sv
// Top level of the rotated clip rectangle stack: input and result registers,
// stack pointer, cached top entries and the two stack stores.
// Depends on rcrs_pkg, rcrs_ram and rcrs_geom.
//
// Usage:
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; all configuration registers reset to zero.
//   Commands enter on the input channel (i_in_valid, o_in_stall) and one
//   result per command leaves on the output channel (o_out_valid,
//   i_out_stall). A transaction completes when valid is high and stall low.
//   Throughput: one command per cycle while the receiver does not stall. A
//   command passes from the input register through the single compute stage
//   into the result register. The top entry of both stores is held in
//   registers and the entry below it is kept ready on the registered read
//   port of each store, so pushes and pops can follow each other every
//   cycle unless the receiver stalls.
//   Reset empties the stack and drops both channels' pending transactions;
//   store contents are not cleared. While the receiver stalls the result
//   holds, one more command may wait in the input register, and then
//   o_in_stall rises.
module rotated_clip_rect_stack_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [11:0]                         i_cfg_data,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic signed [15:0]                  i_pos_x,
    input  logic signed [15:0]                  i_pos_y,
    input  logic signed [15:0]                  i_size_w,
    input  logic signed [15:0]                  i_size_h,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [15:0]                  o_scissor_x,
    output logic signed [15:0]                  o_scissor_y,
    output logic [14:0]                         o_scissor_w,
    output logic [14:0]                         o_scissor_h,
    output logic                                o_visible,
    output logic [1:0]                          o_status,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    o_depth
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    rcrs_pkg::t_cfg       r_cfg;
    logic                 r_in_vld;
    rcrs_pkg::t_cmd       r_cmd;
    rcrs_pkg::t_raw_rect  r_raw;
    logic [CW-1:0]        r_cnt;
    rcrs_pkg::t_clip_rect r_clip_top;
    rcrs_pkg::t_raw_rect  r_raw_top;
    logic                 r_out_vld;
    rcrs_pkg::t_clip_rect r_sc;
    logic                 r_vis;
    rcrs_pkg::t_status    r_status;
    logic [CW-1:0]        r_depth;

    logic                 accept, advance, out_free, full, empty, wr_en;
    logic [CW-1:0]        s_cnt, n_cnt;
    rcrs_pkg::t_clip_rect s_clip_top, below_clip, push_rect, s_sc;
    rcrs_pkg::t_raw_rect  s_raw_top, below_raw;
    rcrs_pkg::t_status    s_status;
    logic                 s_vis, geom_vis;
    logic [CW-1:0]        rd_idx;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcrs_pkg::CFG_WINDOW_WIDTH:  r_cfg.window_width  <= i_cfg_data;
                rcrs_pkg::CFG_WINDOW_HEIGHT: r_cfg.window_height <= i_cfg_data;
                rcrs_pkg::CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                rcrs_pkg::CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                rcrs_pkg::CFG_OFFSET_X:      r_cfg.offset_x      <= i_cfg_data;
                rcrs_pkg::CFG_OFFSET_Y:      r_cfg.offset_y      <= i_cfg_data;
                rcrs_pkg::CFG_ROTATION:
                    r_cfg.rotation <= rcrs_pkg::t_rot'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Handshake: the stage advances when the result register is free
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= rcrs_pkg::t_cmd'(i_cmd);
            r_raw.x <= i_pos_x;
            r_raw.y <= i_pos_y;
            r_raw.w <= i_size_w;
            r_raw.h <= i_size_h;
        end
    end

    // Geometry for push and query
    rcrs_geom u_geom (
        .i_cfg       (r_cfg),
        .i_raw       (r_raw),
        .i_clip_top  (r_clip_top),
        .i_raw_top   (r_raw_top),
        .i_top_vld   (!empty),
        .o_push_rect (push_rect),
        .o_visible   (geom_vis)
    );

    assign full  = (r_cnt == CW'(STACK_DEPTH));
    assign empty = (r_cnt == '0);

    // Decode the command and work out the new stack state
    always_comb begin
        s_cnt      = r_cnt;
        s_clip_top = r_clip_top;
        s_raw_top  = r_raw_top;
        s_status   = rcrs_pkg::ST_OK;
        s_vis      = 1'b0;
        wr_en      = 1'b0;
        case (r_cmd)
            rcrs_pkg::CMD_PUSH: begin
                if (full) begin
                    s_status = rcrs_pkg::ST_PUSH_FULL;
                end else begin
                    wr_en      = advance;
                    s_cnt      = r_cnt + CW'(1);
                    s_clip_top = push_rect;
                    s_raw_top  = r_raw;
                end
            end
            rcrs_pkg::CMD_POP: begin
                if (empty) begin
                    s_status = rcrs_pkg::ST_POP_EMPTY;
                end else begin
                    s_cnt      = r_cnt - CW'(1);
                    s_clip_top = below_clip;
                    s_raw_top  = below_raw;
                end
            end
            rcrs_pkg::CMD_QUERY: begin
                s_vis = geom_vis;
            end
            default: ;
        endcase
    end

    // Scissor after the step: zero when the stack ends up empty
    assign s_sc  = (s_cnt == '0) ? '0 : s_clip_top;
    assign n_cnt = advance ? s_cnt : r_cnt;

    // Keep the entry below the new top on the store read ports
    assign rd_idx = n_cnt - CW'(2);

    rcrs_ram #(
        .WIDTH ($bits(rcrs_pkg::t_clip_rect)),
        .DEPTH (STACK_DEPTH)
    ) u_clip_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (push_rect),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (below_clip)
    );

    rcrs_ram #(
        .WIDTH ($bits(rcrs_pkg::t_raw_rect)),
        .DEPTH (STACK_DEPTH)
    ) u_raw_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_raw),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (below_raw)
    );

    // Stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Cached top entries
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_clip_top <= s_clip_top;
            r_raw_top  <= s_raw_top;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sc     <= s_sc;
            r_vis    <= s_vis;
            r_status <= s_status;
            r_depth  <= s_cnt;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_scissor_x = r_sc.x;
    assign o_scissor_y = r_sc.y;
    assign o_scissor_w = r_sc.w;
    assign o_scissor_h = r_sc.h;
    assign o_visible   = r_vis;
    assign o_status    = r_status;
    assign o_depth     = r_depth;

endmodule

>>> hdl/rcrs_checker.sv
// Port-level checks for the rotated clip rectangle stack, bound to the top.
// Depends on rcrs_pkg and rotated_clip_rect_stack_top.
module rcrs_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [15:0]                  o_scissor_x,
    input  logic signed [15:0]                  o_scissor_y,
    input  logic [14:0]                         o_scissor_w,
    input  logic [14:0]                         o_scissor_h,
    input  logic                                o_visible,
    input  logic [1:0]                          o_status,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]    o_depth
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Hold a stalled result transaction
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            $stable({o_scissor_x, o_scissor_y, o_scissor_w, o_scissor_h,
                     o_visible, o_status, o_depth}))
        else $error("result payload changed while stalled");

    // A rejected push only happens on a full stack
    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == rcrs_pkg::ST_PUSH_FULL) |->
            (o_depth == CW'(STACK_DEPTH)))
        else $error("push rejected below full depth");

    // An empty stack reports a zero scissor
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_depth == '0) |->
            (o_scissor_x == '0 && o_scissor_y == '0 &&
             o_scissor_w == '0 && o_scissor_h == '0))
        else $error("nonzero scissor on empty stack");

    // Errors never come with a visible flag
    a_err_invisible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != rcrs_pkg::ST_OK) |-> !o_visible)
        else $error("visible set on an error result");

endmodule

bind rotated_clip_rect_stack_top rcrs_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rcrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_scissor_x (o_scissor_x),
    .o_scissor_y (o_scissor_y),
    .o_scissor_w (o_scissor_w),
    .o_scissor_h (o_scissor_h),
    .o_visible   (o_visible),
    .o_status    (o_status),
    .o_depth     (o_depth)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the rotated clip rectangle stack: queued push, pop
// and query transactions against an in-bench stack predictor.
// Depends on rcrs_pkg and rotated_clip_rect_stack_top.
module testbench;

    localparam int          STACK_DEPTH    = 16;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASES         = 8;
    localparam int          RANDOM_ITEMS   = 104;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;

    // one command transaction as presented on the input channel
    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } t_rect_cmd;

    // one result transaction
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] w;
        logic        [14:0] h;
        logic               visible;
        rcrs_pkg::t_status  status;
        logic        [4:0]  depth;
    } t_scissor_result;

    // exact-width geometry for the predictor
    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
    } t_box;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_cfg_we = 1'b0;
    logic [2:0]                             i_cfg_idx = '0;
    logic [11:0]                            i_cfg_data = '0;
    logic                                   i_in_valid = 1'b0;
    logic                                   o_in_stall;
    logic [1:0]                             i_cmd = '0;
    logic signed [15:0]                     i_pos_x = '0;
    logic signed [15:0]                     i_pos_y = '0;
    logic signed [15:0]                     i_size_w = '0;
    logic signed [15:0]                     i_size_h = '0;
    logic                                   o_out_valid;
    logic                                   i_out_stall = 1'b0;
    logic signed [15:0]                     o_scissor_x;
    logic signed [15:0]                     o_scissor_y;
    logic [14:0]                            o_scissor_w;
    logic [14:0]                            o_scissor_h;
    logic                                   o_visible;
    logic [1:0]                             o_status;
    logic [$clog2(STACK_DEPTH+1)-1:0]       o_depth;

    // predictor state
    rcrs_pkg::t_cfg     cfg_shadow = '0;
    t_box               clip_stack [STACK_DEPTH];
    t_box               raw_stack [STACK_DEPTH];
    int                 stack_fill = 0;

    t_rect_cmd          pending_cmds [$];
    t_scissor_result    expected_scissors [$];
    t_rect_cmd          cmd_on_bus;
    int                 gen_depth = 0;
    int unsigned        send_idle_pct = 8;
    int unsigned        recv_stall_pct = 56;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;

    rotated_clip_rect_stack_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_size_w    (i_size_w),
        .i_size_h    (i_size_h),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scissor_x (o_scissor_x),
        .o_scissor_y (o_scissor_y),
        .o_scissor_w (o_scissor_w),
        .o_scissor_h (o_scissor_h),
        .o_visible   (o_visible),
        .o_status    (o_status),
        .o_depth     (o_depth)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // closed-interval overlap on both axes
    function automatic bit boxes_touch(t_box a, t_box b);
        bit xo;
        bit yo;
        xo = (a.x >= b.x && a.x <= b.x + b.w) || (b.x >= a.x && b.x <= a.x + a.w);
        yo = (a.y >= b.y && a.y <= b.y + b.h) || (b.y >= a.y && b.y <= a.y + a.h);
        return xo && yo;
    endfunction

    // Advance the predicted stack by one command and return the scissor it reports
    function automatic t_scissor_result clip_stack_step(t_rect_cmd c);
        t_box               raw;
        t_box               m;
        t_box               t;
        t_box               scr;
        t_scissor_result    res;
        longint             ww;
        longint             wh;
        longint             ox;
        longint             oy;
        ww  = cfg_shadow.window_width;
        wh  = cfg_shadow.window_height;
        ox  = cfg_shadow.offset_x;
        oy  = cfg_shadow.offset_y;
        raw = '{c.x, c.y, c.w, c.h};
        res = '0;
        res.status = rcrs_pkg::ST_OK;
        if (c.cmd == rcrs_pkg::CMD_PUSH) begin
            if (stack_fill >= STACK_DEPTH) begin
                res.status = rcrs_pkg::ST_PUSH_FULL;
            end else begin
                // fill open sizes to the screen edge, then rotate into window space
                t = raw;
                if (t.w == 0) t.w = longint'(cfg_shadow.screen_width) - t.x;
                if (t.h == 0) t.h = longint'(cfg_shadow.screen_height) - t.y;
                case (cfg_shadow.rotation)
                    rcrs_pkg::ROT_0: begin
                        m = '{ox + t.x, oy + t.y, t.w, t.h};
                    end
                    rcrs_pkg::ROT_90: begin
                        m = '{ww - oy - t.y - t.h, ox + t.x, t.h, t.w};
                    end
                    rcrs_pkg::ROT_180: begin
                        m = '{ww - ox - t.x - t.w, wh - oy - t.y - t.h, t.w, t.h};
                    end
                    default: begin
                        m = '{oy + t.y, wh - ox - t.x - t.w, t.h, t.w};
                    end
                endcase
                // intersect with the current top, in order, as the corners move
                if (stack_fill > 0) begin
                    t = clip_stack[stack_fill-1];
                    if (t.x > m.x) m.x = t.x;
                    if (t.y > m.y) m.y = t.y;
                    if (t.x + t.w < m.x + m.w) m.w = t.x + t.w - m.x;
                    if (t.y + t.h < m.y + m.h) m.h = t.y + t.h - m.y;
                end
                m.x = clamp(m.x, -32768, 32767);
                m.y = clamp(m.y, -32768, 32767);
                m.w = clamp(m.w, 0, 32767);
                m.h = clamp(m.h, 0, 32767);
                clip_stack[stack_fill] = m;
                raw_stack[stack_fill]  = raw;
                stack_fill++;
            end
        end else if (c.cmd == rcrs_pkg::CMD_POP) begin
            if (stack_fill == 0) res.status = rcrs_pkg::ST_POP_EMPTY;
            else stack_fill--;
        end else if (c.cmd == rcrs_pkg::CMD_QUERY) begin
            scr = '{0, 0, ww, wh};
            res.visible = 1'b1;
            if (raw.w > 0 && raw.x + raw.w <= 0) res.visible = 1'b0;
            if (raw.h > 0 && raw.y + raw.h <= 0) res.visible = 1'b0;
            if (raw.x == ww || raw.y == wh) res.visible = 1'b0;
            if (!boxes_touch(raw, scr)) res.visible = 1'b0;
            if (stack_fill > 0 && !boxes_touch(raw_stack[stack_fill-1], raw))
                res.visible = 1'b0;
        end
        // report the top, or zeros on an empty stack
        if (stack_fill > 0) begin
            t = clip_stack[stack_fill-1];
        end else begin
            t = '{0, 0, 0, 0};
        end
        res.x     = 16'(t.x);
        res.y     = 16'(t.y);
        res.w     = 15'(t.w);
        res.h     = 15'(t.h);
        res.depth = 5'(stack_fill);
        return res;
    endfunction

    // Queue a command and track the depth it leaves behind
    function automatic void queue_cmd(logic [1:0] cmd, logic signed [15:0] x,
                                      logic signed [15:0] y, logic signed [15:0] w,
                                      logic signed [15:0] h);
        pending_cmds.push_back('{cmd, x, y, w, h});
        if (cmd == rcrs_pkg::CMD_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
        if (cmd == rcrs_pkg::CMD_POP && gen_depth > 0) gen_depth--;
    endfunction

    // Mostly on-screen values, with negatives, extremes and raw bit patterns
    function automatic logic signed [15:0] pick_field(int unsigned span,
                                                      int unsigned zero_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < zero_pct) return 16'sd0;
        r = $urandom_range(99);
        if (r < 6) return 16'($urandom);
        if (r < 10) begin
            case ($urandom_range(3))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        if (r < 22) return -16'($urandom_range(span / 4 + 1));
        return 16'($urandom_range(span + 8));
    endfunction

    // Write every register while the block is idle
    task automatic apply_cfg(input rcrs_pkg::t_cfg c);
        rcrs_pkg::t_cfg_idx idx;
        cfg_shadow = c;
        idx = idx.first;
        repeat (idx.num) begin
            @(posedge i_clk);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= idx;
            case (idx)
                rcrs_pkg::CFG_WINDOW_WIDTH:  i_cfg_data <= c.window_width;
                rcrs_pkg::CFG_WINDOW_HEIGHT: i_cfg_data <= c.window_height;
                rcrs_pkg::CFG_SCREEN_WIDTH:  i_cfg_data <= c.screen_width;
                rcrs_pkg::CFG_SCREEN_HEIGHT: i_cfg_data <= c.screen_height;
                rcrs_pkg::CFG_OFFSET_X:      i_cfg_data <= c.offset_x;
                rcrs_pkg::CFG_OFFSET_Y:      i_cfg_data <= c.offset_y;
                default:                     i_cfg_data <= 12'(c.rotation);
            endcase
            idx = idx.next;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every queued command is sent and every result is back
    task automatic drain();
        while (pending_cmds.size() != 0 || i_in_valid || expected_scissors.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(string field, longint want, longint got);
        mismatches++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // Driver: predict on each accepted transaction, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_scissors.push_back(clip_stack_step(cmd_on_bus));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_on_bus = pending_cmds.pop_front();
                    i_cmd      <= cmd_on_bus.cmd;
                    i_pos_x    <= cmd_on_bus.x;
                    i_pos_y    <= cmd_on_bus.y;
                    i_size_w   <= cmd_on_bus.w;
                    i_size_h   <= cmd_on_bus.h;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_scissor_result got;
        t_scissor_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_scissor_x, o_scissor_y, o_scissor_w, o_scissor_h, o_visible,
                    rcrs_pkg::t_status'(o_status), 5'(o_depth)};
            if (expected_scissors.size() == 0) begin
                mismatches++;
                $display("%0t ns: expected no result, got x=%0d y=%0d w=%0d h=%0d depth=%0d",
                         $time, got.x, got.y, got.w, got.h, got.depth);
            end else begin
                want = expected_scissors.pop_front();
                if (got.x !== want.x) report_mismatch("scissor_x", want.x, got.x);
                if (got.y !== want.y) report_mismatch("scissor_y", want.y, got.y);
                if (got.w !== want.w) report_mismatch("scissor_w", want.w, got.w);
                if (got.h !== want.h) report_mismatch("scissor_h", want.h, got.h);
                if (got.visible !== want.visible)
                    report_mismatch("visible", want.visible, got.visible);
                if (got.status !== want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.depth !== want.depth)
                    report_mismatch("depth", want.depth, got.depth);
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run after too long without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        rcrs_pkg::t_cfg phase_cfg [PHASES];
        int unsigned    span;
        logic [1:0]     cmd;
        logic signed [15:0] qx;
        int unsigned    r;
        bit             climbing;

        phase_cfg[0] = '{12'd800, 12'd600, 12'd640, 12'd480, 12'd80, 12'd60,
                         rcrs_pkg::ROT_90};
        phase_cfg[1] = '{12'd640, 12'd480, 12'd640, 12'd480, 12'd0, 12'd0,
                         rcrs_pkg::ROT_0};
        phase_cfg[2] = '{12'd1280, 12'd720, 12'd720, 12'd640, 12'd40, 12'd30,
                         rcrs_pkg::ROT_180};
        phase_cfg[3] = '{12'd480, 12'd800, 12'd800, 12'd480, 12'd0, 12'd16,
                         rcrs_pkg::ROT_270};
        phase_cfg[4] = '{12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff,
                         rcrs_pkg::ROT_270};
        phase_cfg[5] = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, rcrs_pkg::ROT_0};
        phase_cfg[6] = '{12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                         12'($urandom), 12'($urandom),
                         rcrs_pkg::t_rot'($urandom_range(3))};
        phase_cfg[7] = '{12'($urandom_range(64)), 12'($urandom_range(64)),
                         12'($urandom_range(64)), 12'($urandom_range(64)),
                         12'($urandom_range(16)), 12'($urandom_range(16)),
                         rcrs_pkg::t_rot'($urandom_range(3))};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            // swap the idling sides, then run without idling at the end
            if (p == 3) begin
                send_idle_pct  = 56;
                recv_stall_pct = 8;
            end
            if (p == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            apply_cfg(phase_cfg[p]);
            gen_depth = stack_fill;

            if (p == 0) begin
                // empty stack: pop flag, visibility edges against the window
                queue_cmd(rcrs_pkg::CMD_POP, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
                queue_cmd(rcrs_pkg::CMD_QUERY, 16'sd10, 16'sd10, 16'sd20, 16'sd20);
                queue_cmd(rcrs_pkg::CMD_QUERY, 16'sd800, 16'sd10, 16'sd5, 16'sd5);
                queue_cmd(rcrs_pkg::CMD_QUERY, -16'sd50, 16'sd0, 16'sd40, 16'sd10);
                queue_cmd(rcrs_pkg::CMD_QUERY, 16'sd0, -16'sd30, 16'sd10, 16'sd30);
                // open sizes, saturation, negative sizes
                queue_cmd(rcrs_pkg::CMD_PUSH, 16'sd10, 16'sd20, 16'sd0, 16'sd0);
                queue_cmd(rcrs_pkg::CMD_PUSH, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
                queue_cmd(rcrs_pkg::CMD_PUSH, 16'sd5, 16'sd5, -16'sd20, -16'sd20);
                queue_cmd(rcrs_pkg::CMD_QUERY, 16'sd15, 16'sd25, 16'sd4, 16'sd4);
                queue_cmd(rcrs_pkg::CMD_QUERY, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0);
                queue_cmd(CMD_UNUSED, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
                queue_cmd(rcrs_pkg::CMD_PUSH, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff);
                queue_cmd(rcrs_pkg::CMD_QUERY, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
                repeat (5) queue_cmd(rcrs_pkg::CMD_POP, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
            end

            span = phase_cfg[p].window_width;
            if (phase_cfg[p].window_height > span) span = phase_cfg[p].window_height;
            if (phase_cfg[p].screen_width > span) span = phase_cfg[p].screen_width;
            if (phase_cfg[p].screen_height > span) span = phase_cfg[p].screen_height;
            if (span < 16) span = 16;

            // random walk on depth so the stack fills, overflows and empties
            climbing = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if (gen_depth == STACK_DEPTH && $urandom_range(2) == 0) climbing = 1'b0;
                if (gen_depth == 0 && $urandom_range(2) == 0) climbing = 1'b1;
                if ($urandom_range(40) == 0) climbing = !climbing;
                r = $urandom_range(99);
                if (r < 2) cmd = CMD_UNUSED;
                else if (r < 20) cmd = rcrs_pkg::CMD_QUERY;
                else if (climbing ? (r < 82) : (r < 38)) cmd = rcrs_pkg::CMD_PUSH;
                else cmd = rcrs_pkg::CMD_POP;
                qx = pick_field(span, 3);
                if (cmd == rcrs_pkg::CMD_QUERY && $urandom_range(9) == 0)
                    qx = 16'(phase_cfg[p].window_width);
                queue_cmd(cmd, qx, pick_field(span, 3), pick_field(span, 20),
                          pick_field(span, 20));
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_scissors.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
